### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers on a clock and an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/lfpid_pkg.sv
// ----------------------------------------------------------------------------
// lfpid_pkg
// types, constants and the sensor position table of the line follower
// ----------------------------------------------------------------------------
package lfpid_pkg;

	localparam int unsigned PULSE_MAX   = 20000;
	localparam logic [5:0]  LOST_POS    = 6'd44;
	localparam logic [5:0]  HALF_SPAN   = 6'd20;
	localparam int unsigned PROD_W      = 58;
	localparam int unsigned CHG_W       = 60;

	localparam logic [1:0] RS_IDLE  = 2'd0;
	localparam logic [1:0] RS_RUN   = 2'd1;
	localparam logic [1:0] RS_BRAKE = 2'd2;

	localparam logic [2:0] CFG_SETPOINT   = 3'd0;
	localparam logic [2:0] CFG_GAIN_P     = 3'd1;
	localparam logic [2:0] CFG_GAIN_I     = 3'd2;
	localparam logic [2:0] CFG_GAIN_D     = 3'd3;
	localparam logic [2:0] CFG_LEFT_BASE  = 3'd4;
	localparam logic [2:0] CFG_RIGHT_BASE = 3'd5;
	localparam logic [2:0] CFG_RIGHT_CTR  = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IE_MUL,
		ST_IE_ACC,
		ST_LO_MUL,
		ST_LO_ACC,
		ST_HI_MUL,
		ST_HI_ACC,
		ST_P_MUL,
		ST_P_ACC,
		ST_DIV,
		ST_D_MUL,
		ST_D_ACC,
		ST_SAT,
		ST_OUT
	} lfpid_state_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       full;
		logic       run;
		logic       brake;
		logic       clr_int;
	} front_t;

	typedef struct packed {
		logic               en;
		logic signed [24:0] a;
		logic signed [32:0] b;
	} mac_op_t;

	function automatic logic [3:0] pos_lookup(input logic [2:0] code);
		logic [3:0] v;
		unique case (code)
			3'd1: v = 4'd8;
			3'd2: v = 4'd5;
			3'd3: v = 4'd6;
			3'd4: v = 4'd2;
			3'd6: v = 4'd4;
			3'd7: v = 4'd5;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/lfpid_if.sv
// ----------------------------------------------------------------------------
// lfpid_in_if / lfpid_out_if
// valid/ready channels carrying sensor items and controller results
// ----------------------------------------------------------------------------
interface lfpid_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  left_code;
	logic [2:0]  right_code;
	logic [23:0] elapsed_us;

	modport source (output valid, left_code, right_code, elapsed_us, input ready);
	modport sink (input valid, left_code, right_code, elapsed_us, output ready);
endinterface

interface lfpid_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] left_pulse_us;
	logic [14:0] right_pulse_us;
	logic        motor_enable;
	logic [1:0]  run_state;
	logic [5:0]  line_position_half;
	logic        full_line;

	modport source (output valid, left_pulse_us, right_pulse_us, motor_enable, run_state,
		line_position_half, full_line, input ready);
	modport sink (input valid, left_pulse_us, right_pulse_us, motor_enable, run_state,
		line_position_half, full_line, output ready);
endinterface

### hw/rtl/lfpid_front.sv
// ----------------------------------------------------------------------------
// lfpid_front
// sensor decode, line position and run state tracking
// ----------------------------------------------------------------------------
module lfpid_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd,
	input  logic [2:0]      left_code,
	input  logic [2:0]      right_code,
	output lfpid_pkg::front_t info
);
	import lfpid_pkg::*;

	logic       run_q;
	logic [1:0] cnt_q;
	logic       exit_seen_q;
	logic [5:0] prev_pos_q;

	logic [3:0] sl, sr;
	logic [5:0] pos_raw, pos;
	logic       full, exit_ev, run_n, brake_n;
	logic [1:0] cnt_n;

	always_comb begin
		sl = pos_lookup(left_code);
		sr = pos_lookup(right_code);
		priority if (sl != 4'd0 && sr != 4'd0) begin
			pos_raw = 6'({2'b0, sl} + {2'b0, sr} + 6'd10);
		end else if (sl != 4'd0) begin
			pos_raw = {1'b0, sl, 1'b0};
		end else if (sr != 4'd0) begin
			pos_raw = 6'(({2'b0, sr} + 6'd10) << 1);
		end else begin
			pos_raw = 6'd0;
		end
		pos = (pos_raw == 6'd0 && prev_pos_q >= HALF_SPAN) ? LOST_POS : pos_raw;
		full = (left_code == 3'd7) && (right_code == 3'd7);
		exit_ev = !full && !exit_seen_q;

		run_n = run_q;
		cnt_n = cnt_q;
		brake_n = 1'b0;
		if (exit_ev) begin
			if (!run_q) begin
				cnt_n = 2'd0;
			end
			run_n = 1'b1;
			if (cnt_n < 2'd2) begin
				cnt_n = cnt_n + 2'd1;
			end else if (cnt_n == 2'd2) begin
				cnt_n = 2'd3;
				run_n = 1'b0;
				brake_n = 1'b1;
			end
		end

		info.pos = pos;
		info.full = full;
		info.run = run_n;
		info.brake = brake_n;
		info.clr_int = exit_ev || pos == 6'd0 || pos == LOST_POS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 2'd0;
			exit_seen_q <= 1'b0;
			prev_pos_q <= HALF_SPAN;
		end else if (upd) begin
			run_q <= run_n;
			cnt_q <= cnt_n;
			exit_seen_q <= !full;
			prev_pos_q <= pos;
		end
	end

endmodule

### hw/rtl/lfpid_mac.sv
// ----------------------------------------------------------------------------
// lfpid_mac
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module lfpid_mac (
	input  logic                                    clk,
	input  lfpid_pkg::mac_op_t                      op,
	output logic signed [lfpid_pkg::PROD_W-1:0]     prod_q
);
	import lfpid_pkg::*;

	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= op.a * op.b;
		end
	end

endmodule

### hw/rtl/line_follower_pid_controller_top.sv
// ----------------------------------------------------------------------------
// line_follower_pid_controller_top
// PID line follower: one sensor item in, one motor command item out
// ----------------------------------------------------------------------------
// item_in carries two 3-bit sensor codes and the microseconds since the last
// tick; item_out carries both pulse widths, enable, run state, line position
// and the full-line flag. The cfg port writes the seven registers by index.
// An item is taken only when the block is idle. A tick that does not run the
// controller has its result valid in the cycle after acceptance. A running
// tick steps one shared multiplier through five products plus a restoring
// derivative divide, then saturates both pulse widths before its result
// is valid. The result is held until item_out.ready; no new item is taken
// meanwhile, so a stalled receiver stalls the sender. Reset loads the
// register defaults, clears the integrator and run state, and leaves the
// block idle with no result.
// ----------------------------------------------------------------------------
module line_follower_pid_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	lfpid_in_if.sink    item_in,
	lfpid_out_if.source item_out
);
	import lfpid_pkg::*;

	logic        [5:0]  setpoint_q;
	logic        [9:0]  gain_p_q;
	logic signed [23:0] gain_i_q;
	logic        [9:0]  gain_d_q;
	logic        [14:0] left_base_q;
	logic        [14:0] right_base_q;
	logic        [14:0] right_ctr_q;

	lfpid_state_t state_q, state_n;
	front_t       front;
	mac_op_t      mac_op;
	logic signed [PROD_W-1:0] prod_q;

	logic        [23:0] elapsed_q;
	logic signed [5:0]  err_q;
	logic signed [5:0]  prev_err_q;
	logic signed [47:0] integral_q;
	logic signed [CHG_W-1:0] chg_q;
	logic        [14:0] held_left_q;
	logic        [14:0] held_right_q;
	logic               enable_q;
	logic        [1:0]  shown_q;
	logic        [5:0]  pos_q;
	logic               full_q;
	logic        [5:0]  rem_q;
	logic        [5:0]  quo_q;
	logic               div_neg_q;
	logic        [2:0]  cnt_q;

	logic        in_acc;
	logic signed [6:0] diff_pe, err_full;
	logic signed [6:0] diff_d;
	logic        [6:0] mag_d;
	logic        [6:0] div_r;
	logic        [6:0] div_d;
	logic signed [6:0] deriv;
	logic signed [48:0] int_sum;
	logic signed [47:0] int_sat;
	logic signed [CHG_W-1:0] left_sum, right_sum;
	logic        [14:0] left_sat, right_sat;

	assign in_acc = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == ST_IDLE);

	lfpid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (in_acc),
		.left_code  (item_in.left_code),
		.right_code (item_in.right_code),
		.info       (front)
	);

	lfpid_mac u_mac (
		.clk    (clk),
		.op     (mac_op),
		.prod_q (prod_q)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= 6'd10;
			gain_p_q <= 10'd200;
			gain_i_q <= 24'sd0;
			gain_d_q <= 10'd15;
			left_base_q <= 15'd18000;
			right_base_q <= 15'd18000;
			right_ctr_q <= 15'd10000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SETPOINT:   setpoint_q <= cfg_data[5:0];
				CFG_GAIN_P:     gain_p_q <= cfg_data[9:0];
				CFG_GAIN_I:     gain_i_q <= cfg_data;
				CFG_GAIN_D:     gain_d_q <= cfg_data[9:0];
				CFG_LEFT_BASE:  left_base_q <= cfg_data[14:0];
				CFG_RIGHT_BASE: right_base_q <= cfg_data[14:0];
				CFG_RIGHT_CTR:  right_ctr_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// datapath helpers
	always_comb begin
		diff_pe = 7'({1'b0, front.pos}) - 7'({1'b0, setpoint_q});
		err_full = (diff_pe + {6'd0, diff_pe[6]}) >>> 1;

		diff_d = 7'({err_q[5], err_q}) - 7'({prev_err_q[5], prev_err_q});
		mag_d = diff_d[6] ? 7'(-diff_d) : diff_d;

		div_r = {rem_q, quo_q[5]};
		div_d = {1'b0, elapsed_q[5:0]};

		if (elapsed_q == 24'd0 || elapsed_q[23:6] != 18'd0) begin
			deriv = 7'sd0;
		end else begin
			deriv = div_neg_q ? 7'(-{1'b0, quo_q}) : 7'({1'b0, quo_q});
		end

		int_sum = {integral_q[47], integral_q} + prod_q[48:0];
		if (int_sum[48] != int_sum[47]) begin
			int_sat = int_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			int_sat = int_sum[47:0];
		end

		left_sum = CHG_W'({1'b0, left_base_q}) + chg_q;
		right_sum = CHG_W'(signed'({2'b0, right_ctr_q, 1'b0}) - signed'({3'b0, right_base_q}))
			+ chg_q;
		if (left_sum < 0) begin
			left_sat = 15'd0;
		end else if (left_sum > CHG_W'(PULSE_MAX)) begin
			left_sat = 15'(PULSE_MAX);
		end else begin
			left_sat = left_sum[14:0];
		end
		if (right_sum < 0) begin
			right_sat = 15'd0;
		end else if (right_sum > CHG_W'(PULSE_MAX)) begin
			right_sat = 15'(PULSE_MAX);
		end else begin
			right_sat = right_sum[14:0];
		end
	end

	// sequencer next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_n = front.run ? ST_IE_MUL : ST_OUT;
			ST_IE_MUL: state_n = ST_IE_ACC;
			ST_IE_ACC: state_n = ST_LO_MUL;
			ST_LO_MUL: state_n = ST_LO_ACC;
			ST_LO_ACC: state_n = ST_HI_MUL;
			ST_HI_MUL: state_n = ST_HI_ACC;
			ST_HI_ACC: state_n = ST_P_MUL;
			ST_P_MUL:  state_n = ST_P_ACC;
			ST_P_ACC:  state_n = ST_DIV;
			ST_DIV:    if (cnt_q == 3'd5) state_n = ST_D_MUL;
			ST_D_MUL:  state_n = ST_D_ACC;
			ST_D_ACC:  state_n = ST_SAT;
			ST_SAT:    state_n = ST_OUT;
			ST_OUT:    if (item_out.ready) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		mac_op.en = 1'b0;
		mac_op.a = 25'sd0;
		mac_op.b = 33'sd0;
		unique case (state_q)
			ST_IE_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a = 25'({{19{err_q[5]}}, err_q});
				mac_op.b = 33'({9'd0, elapsed_q});
			end
			ST_LO_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a = 25'({gain_i_q[23], gain_i_q});
				mac_op.b = 33'({17'd0, integral_q[15:0]});
			end
			ST_HI_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a = 25'({gain_i_q[23], gain_i_q});
				mac_op.b = 33'({integral_q[47], integral_q[47:16]});
			end
			ST_P_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a = 25'({{19{err_q[5]}}, err_q});
				mac_op.b = 33'({23'd0, gain_p_q});
			end
			ST_D_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a = 25'({{18{deriv[6]}}, deriv});
				mac_op.b = 33'({23'd0, gain_d_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integral_q <= 48'sd0;
			prev_err_q <= 6'sd0;
			held_left_q <= 15'd0;
			held_right_q <= 15'd0;
			enable_q <= 1'b0;
			shown_q <= RS_IDLE;
			cnt_q <= 3'd0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (front.clr_int) integral_q <= 48'sd0;
						if (front.run) begin
							enable_q <= 1'b1;
							shown_q <= RS_RUN;
						end else if (front.brake) begin
							shown_q <= RS_BRAKE;
						end else begin
							enable_q <= 1'b0;
							shown_q <= RS_IDLE;
						end
					end
				end
				ST_IE_MUL: cnt_q <= 3'd0;
				ST_IE_ACC: integral_q <= int_sat;
				ST_DIV:    cnt_q <= cnt_q + 3'd1;
				ST_SAT: begin
					held_left_q <= left_sat;
					held_right_q <= right_sat;
					prev_err_q <= err_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			elapsed_q <= item_in.elapsed_us;
			err_q <= err_full[5:0];
			pos_q <= front.pos;
			full_q <= front.full;
		end
		unique case (state_q)
			ST_IE_MUL: begin
				rem_q <= 6'd0;
				quo_q <= mag_d[5:0];
				div_neg_q <= diff_d[6];
			end
			ST_LO_ACC: chg_q <= CHG_W'(prod_q >>> 16);
			ST_HI_ACC, ST_P_ACC, ST_D_ACC: chg_q <= chg_q + CHG_W'(prod_q);
			ST_DIV: begin
				if (div_r >= div_d) begin
					rem_q <= 6'(div_r - div_d);
					quo_q <= {quo_q[4:0], 1'b1};
				end else begin
					rem_q <= div_r[5:0];
					quo_q <= {quo_q[4:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign item_out.valid = (state_q == ST_OUT);
	assign item_out.left_pulse_us = held_left_q;
	assign item_out.right_pulse_us = held_right_q;
	assign item_out.motor_enable = enable_q;
	assign item_out.run_state = shown_q;
	assign item_out.line_position_half = pos_q;
	assign item_out.full_line = full_q;

`include "assert_macros.svh"

	`AST_IMPL(a_no_take_while_out, clk, arst_n, item_out.valid, !item_in.ready)
	`AST_IMPL(a_width_range, clk, arst_n, item_out.valid,
		held_left_q <= 15'd20000 && held_right_q <= 15'd20000)
	`AST_IMPL(a_run_enables, clk, arst_n, item_out.valid && shown_q == RS_RUN, enable_q)
	`AST_NEXT(a_idle_tick_fast, clk, arst_n, in_acc && !front.run, item_out.valid)

endmodule
